// ===== sv/alhk_pkg.sv =====
// alhk_pkg: shared types, character codes and the us-layout keystroke table
// used by the ascii line buffer to hid keystroke core
// no dependencies
package alhk_pkg;

    localparam int CNT_W = 6;

    localparam logic [7:0] CHAR_NONE   = 8'h00;
    localparam logic [7:0] CHAR_BKSP   = 8'h08;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_ONE    = 8'h31;
    localparam logic [7:0] CHAR_UP_A   = 8'h41;
    localparam logic [7:0] CHAR_LO_A   = 8'h61;
    localparam logic [7:0] CHAR_TOGGLE = 8'h60;
    localparam logic [7:0] CHAR_DEL    = 8'h7F;

    localparam logic [6:0] USAGE_NONE   = 7'h00;
    localparam logic [6:0] USAGE_ALPHA  = 7'h04;
    localparam logic [6:0] USAGE_DIGIT1 = 7'h1E;
    localparam logic [6:0] USAGE_DIGIT0 = 7'h27;
    localparam logic [6:0] USAGE_RETURN = 7'h28;
    localparam logic [6:0] USAGE_BKSP   = 7'h2A;
    localparam logic [6:0] USAGE_TAB    = 7'h2B;
    localparam logic [6:0] USAGE_SPACE  = 7'h2C;

    typedef struct packed {
        logic       shift;
        logic [6:0] usage;
    } t_map;

    function automatic t_map map_char(input logic [7:0] c);
        t_map m;
        m.shift = 1'b0;
        m.usage = USAGE_NONE;
        case (c) inside
            [8'h61:8'h7A]: m.usage = USAGE_ALPHA + 7'(c - CHAR_LO_A);
            [8'h41:8'h5A]: begin
                m.shift = 1'b1;
                m.usage = USAGE_ALPHA + 7'(c - CHAR_UP_A);
            end
            [8'h31:8'h39]: m.usage = USAGE_DIGIT1 + 7'(c - CHAR_ONE);
            CHAR_ZERO:       m.usage = USAGE_DIGIT0;
            CHAR_SPACE:      m.usage = USAGE_SPACE;
            CHAR_LF, CHAR_CR: m.usage = USAGE_RETURN;
            CHAR_BKSP:       m.usage = USAGE_BKSP;
            CHAR_TAB:        m.usage = USAGE_TAB;
            8'h21: m = '{shift: 1'b1, usage: 7'h1E};
            8'h40: m = '{shift: 1'b1, usage: 7'h1F};
            8'h23: m = '{shift: 1'b1, usage: 7'h20};
            8'h24: m = '{shift: 1'b1, usage: 7'h21};
            8'h25: m = '{shift: 1'b1, usage: 7'h22};
            8'h5E: m = '{shift: 1'b1, usage: 7'h23};
            8'h26: m = '{shift: 1'b1, usage: 7'h24};
            8'h2A: m = '{shift: 1'b1, usage: 7'h25};
            8'h28: m = '{shift: 1'b1, usage: 7'h26};
            8'h29: m = '{shift: 1'b1, usage: 7'h27};
            8'h2D: m = '{shift: 1'b0, usage: 7'h2D};
            8'h5F: m = '{shift: 1'b1, usage: 7'h2D};
            8'h3D: m = '{shift: 1'b0, usage: 7'h2E};
            8'h2B: m = '{shift: 1'b1, usage: 7'h2E};
            8'h5B: m = '{shift: 1'b0, usage: 7'h2F};
            8'h7B: m = '{shift: 1'b1, usage: 7'h2F};
            8'h5D: m = '{shift: 1'b0, usage: 7'h30};
            8'h7D: m = '{shift: 1'b1, usage: 7'h30};
            8'h5C: m = '{shift: 1'b0, usage: 7'h31};
            8'h7C: m = '{shift: 1'b1, usage: 7'h31};
            8'h3B: m = '{shift: 1'b0, usage: 7'h33};
            8'h3A: m = '{shift: 1'b1, usage: 7'h33};
            8'h27: m = '{shift: 1'b0, usage: 7'h34};
            8'h22: m = '{shift: 1'b1, usage: 7'h34};
            8'h60: m = '{shift: 1'b0, usage: 7'h35};
            8'h7E: m = '{shift: 1'b1, usage: 7'h35};
            8'h2C: m = '{shift: 1'b0, usage: 7'h36};
            8'h3C: m = '{shift: 1'b1, usage: 7'h36};
            8'h2E: m = '{shift: 1'b0, usage: 7'h37};
            8'h3E: m = '{shift: 1'b1, usage: 7'h37};
            8'h2F: m = '{shift: 1'b0, usage: 7'h38};
            8'h3F: m = '{shift: 1'b1, usage: 7'h38};
            default: m.usage = USAGE_NONE;
        endcase
        return m;
    endfunction

endpackage

// ===== sv/ascii_line_buffer_to_hid_keys_core.sv =====
// ascii_line_buffer_to_hid_keys_core: ascii keys to us-layout hid keystrokes,
// live mode or line buffer mode; depends on alhk_pkg and alhk_ram
// a live keystroke is registered and appears in the cycle after its transfer
// throughput: one key per cycle while the output is free; a flush reads each
// buffered key from ram, then maps it, then sends enter, input held off
// reset: synchronous active low; clears state, mode, count, output valid; ram not cleared
module ascii_line_buffer_to_hid_keys_core
    import alhk_pkg::*;
#(
    parameter int BUF_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_key_char,
    input  logic       i_host_connected,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_shift_held,
    output logic [6:0] o_key_code,
    output logic       o_is_last
);

    localparam int ADDR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_MAP   = 4'b0100,
        S_ENTER = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic             r_mode, n_mode;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;
    logic             r_shift, n_shift;
    logic [6:0]       r_code, n_code;
    logic             r_last, n_last;

    logic       w_accept;
    logic       w_slot_free;
    logic       w_wr_en;
    logic       w_rd_en;
    logic [7:0] w_rd_data;
    t_map       w_live_map;
    t_map       w_buf_map;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && w_slot_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_live_map  = map_char(i_key_char);
    assign w_buf_map   = map_char(w_rd_data);

    alhk_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_text_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(r_count[ADDR_W-1:0]),
        .i_wr_data(i_key_char),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(r_idx[ADDR_W-1:0]),
        .o_rd_data(w_rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_shift     = r_shift;
        n_code      = r_code;
        n_last      = r_last;
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept && i_key_char != CHAR_NONE) begin
                    if (i_key_char == CHAR_TOGGLE) begin
                        n_mode  = !r_mode;
                        n_count = '0;
                    end else if (i_host_connected) begin
                        if (!r_mode) begin
                            if (w_live_map.usage != USAGE_NONE) begin
                                n_out_valid = 1'b1;
                                n_shift     = w_live_map.shift;
                                n_code      = w_live_map.usage;
                                n_last      = 1'b1;
                            end
                        end else if (i_key_char == CHAR_CR || i_key_char == CHAR_LF) begin
                            if (r_count != '0) begin
                                n_idx   = '0;
                                n_state = S_READ;
                            end
                        end else if (i_key_char == CHAR_BKSP || i_key_char == CHAR_DEL) begin
                            if (r_count != '0) begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end else if (r_count < CNT_W'(BUF_DEPTH)) begin
                            w_wr_en = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                end
            end
            S_READ: begin
                w_rd_en = 1'b1;
                n_state = S_MAP;
            end
            S_MAP: begin
                if (w_buf_map.usage == USAGE_NONE || w_slot_free) begin
                    if (w_buf_map.usage != USAGE_NONE) begin
                        n_out_valid = 1'b1;
                        n_shift     = w_buf_map.shift;
                        n_code      = w_buf_map.usage;
                        n_last      = 1'b0;
                    end
                    if (r_idx + CNT_W'(1) == r_count) begin
                        n_state = S_ENTER;
                    end else begin
                        n_idx   = r_idx + CNT_W'(1);
                        n_state = S_READ;
                    end
                end
            end
            S_ENTER: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_shift     = 1'b0;
                    n_code      = USAGE_RETURN;
                    n_last      = 1'b1;
                    n_count     = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_shift <= n_shift;
        r_code  <= n_code;
        r_last  <= n_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_shift_held = r_shift;
    assign o_key_code   = r_code;
    assign o_is_last    = r_last;

endmodule

// ===== sv/alhk_ram.sv =====
// alhk_ram: generic single write port, single read port ram with registered read
// no dependencies
module alhk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
